[hw/rtl/gnh_pkg.sv]
package gnh_pkg;

    // Neighbor table geometry
    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    // Configuration port
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    typedef enum logic [1:0] {
        REG_SELF_ADDR = 2'd0,
        REG_SELF_X    = 2'd1,
        REG_SELF_Y    = 2'd2,
        REG_NONE      = 2'd3
    } reg_idx_t;

    // Flag bit positions within a stored entry
    localparam int FLAG_PHYS = 0;
    localparam int FLAG_TRI  = 1;
    localparam int FLAG_ATT  = 2;

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_t;

    typedef enum logic [2:0] {
        STAT_GREEDY   = 3'd0,
        STAT_FALLBACK = 3'd1,
        STAT_NONE     = 3'd2,
        STAT_UNKNOWN  = 3'd3,
        STAT_WRITTEN  = 3'd4
    } status_t;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_LIM   = 5'b00010,
        S_SCAN  = 5'b00100,
        S_DRAIN = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    typedef struct packed {
        logic               command;
        logic [3:0]         slot;
        logic [31:0]        node_addr;
        logic signed [15:0] coord_x;
        logic signed [15:0] coord_y;
        logic               entry_valid;
        logic               is_physical;
        logic               is_triangulation;
        logic               attached;
        logic               dest_known;
        logic [31:0]        ban_addr;
    } item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] next_hop;
    } result_t;

    // Squared distance needs 33 bits: two squares below 2^32 each
    localparam int DIST_W = 33;

endpackage

[hw/rtl/greedy_next_hop_select.sv]
// Channel   | Signals                               | Transaction
// ----------+---------------------------------------+-----------------------------------
// command   | start, busy, item (item_t)            | start && !busy at a rising edge
// result    | done, result (result_t)               | one cycle with done high
// config    | psel penable pwrite paddr pwdata      | psel && penable && pwrite && pready
//           | prdata pready                         |
//
// A table write or a query with an unknown destination answers in the cycle
// after acceptance, and busy stays low, so such commands may come every cycle.
// A full query runs from acceptance to the done strobe through one pass of the
// shared distance unit over self plus TABLE_DEPTH entries, a drain state for
// that unit's output register and a decision state. busy is high until the
// strobe. rst_n clears the table valid bits, config registers and sequencer at
// once; no clearing pass. The receiver cannot stall; results are never held.
module greedy_next_hop_select
    import gnh_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // Command channel
    input  logic               start,
    output logic               busy,
    input  item_t              item,
    // Result channel
    output logic               done,
    output result_t            result,
    // Configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    // ---------------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------------
    logic [31:0]        self_addr_reg;
    logic signed [15:0] self_x_reg;
    logic signed [15:0] self_y_reg;
    logic               cfg_wr;
    reg_idx_t           cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            self_addr_reg <= '0;
            self_x_reg    <= '0;
            self_y_reg    <= '0;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_SELF_ADDR: self_addr_reg <= pwdata;
                REG_SELF_X:    self_x_reg    <= pwdata[15:0];
                REG_SELF_Y:    self_y_reg    <= pwdata[15:0];
                default:       ;
            endcase
        end
    end

    // Read back; coordinates sign-extend to the bus width
    always_comb
    begin
        case (cfg_idx)
            REG_SELF_ADDR: prdata = self_addr_reg;
            REG_SELF_X:    prdata = {{(PDATA_W-16){self_x_reg[15]}}, self_x_reg};
            REG_SELF_Y:    prdata = {{(PDATA_W-16){self_y_reg[15]}}, self_y_reg};
            default:       prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------------
    // Neighbor table: valid bits reset, payload undefined until written
    // ---------------------------------------------------------------------
    logic [TABLE_DEPTH-1:0] tbl_valid_reg;
    logic [31:0]            tbl_addr_reg [TABLE_DEPTH];
    logic signed [15:0]     tbl_x_reg    [TABLE_DEPTH];
    logic signed [15:0]     tbl_y_reg    [TABLE_DEPTH];
    logic [2:0]             tbl_flags_reg[TABLE_DEPTH];

    logic accept;
    logic tbl_wr;
    logic [IDX_W-1:0] wr_idx;

    assign accept = start && !busy;
    assign tbl_wr = accept && (item.command == CMD_WRITE)
                    && ({28'd0, item.slot} < 32'(TABLE_DEPTH));
    assign wr_idx = IDX_W'(item.slot);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tbl_valid_reg <= '0;
        end
        else if (tbl_wr)
        begin
            tbl_valid_reg[wr_idx] <= item.entry_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tbl_wr)
        begin
            tbl_addr_reg[wr_idx]  <= item.node_addr;
            tbl_x_reg[wr_idx]     <= item.coord_x;
            tbl_y_reg[wr_idx]     <= item.coord_y;
            tbl_flags_reg[wr_idx] <= {item.attached, item.is_triangulation, item.is_physical};
        end
    end

    // ---------------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------------
    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;

    // Query operands, held for the whole scan
    logic [31:0]        dest_addr_reg;
    logic signed [15:0] dest_x_reg;
    logic signed [15:0] dest_y_reg;
    logic [31:0]        ban_reg;

    // Tag that travels alongside the distance unit's output register
    logic               p_vld_reg, p_vld_next;
    logic               p_lim_reg, p_lim_next;
    logic               p_c1_reg, p_c1_next;
    logic               p_c2_reg, p_c2_next;
    logic [31:0]        p_addr_reg, p_addr_next;

    // Distance of self to the destination; the greedy pass must beat it
    logic [DIST_W-1:0]  lim_reg, lim_next;

    // Running best of each pass
    logic               f1_reg, f1_next;
    logic [DIST_W-1:0]  bd1_reg, bd1_next;
    logic [31:0]        ba1_reg, ba1_next;
    logic               f2_reg, f2_next;
    logic [DIST_W-1:0]  bd2_reg, bd2_next;
    logic [31:0]        ba2_reg, ba2_next;

    logic               done_reg, done_next;
    result_t            result_reg, result_next;

    logic               q_start;
    logic signed [15:0] op_x;
    logic signed [15:0] op_y;
    logic [31:0]        ent_addr;
    logic [2:0]         ent_flags;
    logic               ent_valid;
    logic [31:0]        sq_x;
    logic [31:0]        sq_y;
    logic [DIST_W-1:0]  dist_sum;
    logic               better1;
    logic               better2;

    assign q_start = accept && (item.command == CMD_QUERY) && item.dest_known;

    assign ent_addr  = tbl_addr_reg[idx_reg];
    assign ent_flags = tbl_flags_reg[idx_reg];
    assign ent_valid = tbl_valid_reg[idx_reg];

    // Feed self in the limit cycle, then the table entry under the scan index
    assign op_x = (state_reg == S_LIM) ? self_x_reg : tbl_x_reg[idx_reg];
    assign op_y = (state_reg == S_LIM) ? self_y_reg : tbl_y_reg[idx_reg];

    gnh_dist_unit u_dist (
        .clk      (clk),
        .ax       (op_x),
        .ay       (op_y),
        .bx       (dest_x_reg),
        .by       (dest_y_reg),
        .sq_x_reg (sq_x),
        .sq_y_reg (sq_y)
    );

    assign dist_sum = {1'b0, sq_x} + {1'b0, sq_y};

    // Smaller distance wins; ties go to the lower address
    assign better1 = !f1_reg || (dist_sum < bd1_reg)
                     || ((dist_sum == bd1_reg) && (p_addr_reg < ba1_reg));
    assign better2 = !f2_reg || (dist_sum < bd2_reg)
                     || ((dist_sum == bd2_reg) && (p_addr_reg < ba2_reg));

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        lim_next    = lim_reg;
        f1_next     = f1_reg;
        bd1_next    = bd1_reg;
        ba1_next    = ba1_reg;
        f2_next     = f2_reg;
        bd2_next    = bd2_reg;
        ba2_next    = ba2_reg;
        done_next   = 1'b0;
        result_next = result_reg;

        // Issue: classify the entry going into the distance unit
        p_vld_next  = (state_reg == S_LIM) || (state_reg == S_SCAN);
        p_lim_next  = (state_reg == S_LIM);
        p_addr_next = ent_addr;
        p_c1_next   = (state_reg == S_SCAN) && ent_valid
                      && ent_flags[FLAG_PHYS] && ent_flags[FLAG_ATT]
                      && (ent_addr != ban_reg);
        p_c2_next   = (state_reg == S_SCAN) && ent_valid
                      && ent_flags[FLAG_TRI] && ent_flags[FLAG_ATT]
                      && (ent_addr != self_addr_reg)
                      && (ent_addr != dest_addr_reg)
                      && (ent_addr != ban_reg);

        // Consume: fold the distance from the last issue into both passes
        if (p_vld_reg)
        begin
            if (p_lim_reg)
            begin
                lim_next = dist_sum;
            end
            if (p_c1_reg && (dist_sum < lim_reg) && better1)
            begin
                f1_next  = 1'b1;
                bd1_next = dist_sum;
                ba1_next = p_addr_reg;
            end
            if (p_c2_reg && better2)
            begin
                f2_next  = 1'b1;
                bd2_next = dist_sum;
                ba2_next = p_addr_reg;
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (item.command == CMD_WRITE)
                    begin
                        done_next   = 1'b1;
                        result_next = '{status: STAT_WRITTEN, next_hop: '0};
                    end
                    else if (!item.dest_known)
                    begin
                        done_next   = 1'b1;
                        result_next = '{status: STAT_UNKNOWN, next_hop: '0};
                    end
                    else
                    begin
                        state_next = S_LIM;
                        idx_next   = '0;
                        f1_next    = 1'b0;
                        f2_next    = 1'b0;
                    end
                end
            end
            S_LIM:
            begin
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (idx_reg == IDX_W'(TABLE_DEPTH - 1))
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // A greedy pick that is this node itself drops to the fallback
                done_next  = 1'b1;
                state_next = S_IDLE;
                if (f1_reg && (ba1_reg != self_addr_reg))
                begin
                    result_next = '{status: STAT_GREEDY, next_hop: ba1_reg};
                end
                else if (f2_reg)
                begin
                    result_next = '{status: STAT_FALLBACK, next_hop: ba2_reg};
                end
                else
                begin
                    result_next = '{status: STAT_NONE, next_hop: '0};
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            p_vld_reg <= 1'b0;
            p_lim_reg <= 1'b0;
            f1_reg    <= 1'b0;
            f2_reg    <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            p_vld_reg <= p_vld_next;
            p_lim_reg <= p_lim_next;
            f1_reg    <= f1_next;
            f2_reg    <= f2_next;
            done_reg  <= done_next;
        end
    end

    // Payload; hold query operands from acceptance to the end of the scan
    always_ff @(posedge clk)
    begin
        if (q_start)
        begin
            dest_addr_reg <= item.node_addr;
            dest_x_reg    <= item.coord_x;
            dest_y_reg    <= item.coord_y;
            ban_reg       <= item.ban_addr;
        end
        p_c1_reg   <= p_c1_next;
        p_c2_reg   <= p_c2_next;
        p_addr_reg <= p_addr_next;
        lim_reg    <= lim_next;
        bd1_reg    <= bd1_next;
        ba1_reg    <= ba1_next;
        bd2_reg    <= bd2_next;
        ba2_reg    <= ba2_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

[hw/rtl/gnh_dist_unit.sv]
module gnh_dist_unit
    import gnh_pkg::*;
(
    input  logic               clk,
    input  logic signed [15:0] ax,
    input  logic signed [15:0] ay,
    input  logic signed [15:0] bx,
    input  logic signed [15:0] by,
    output logic [31:0]        sq_x_reg,
    output logic [31:0]        sq_y_reg
);

    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic signed [33:0] px;
    logic signed [33:0] py;
    logic [31:0]        sq_x_next;
    logic [31:0]        sq_y_next;

    // Differences span 17 bits; squares stay below 2^32
    always_comb
    begin
        dx        = $signed({ax[15], ax}) - $signed({bx[15], bx});
        dy        = $signed({ay[15], ay}) - $signed({by[15], by});
        px        = dx * dx;
        py        = dy * dy;
        sq_x_next = px[31:0];
        sq_y_next = py[31:0];
    end

    always_ff @(posedge clk)
    begin
        sq_x_reg <= sq_x_next;
        sq_y_reg <= sq_y_next;
    end

endmodule

[hw/rtl/gnh_checker.sv]
module gnh_checker
    import gnh_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    start,
    input logic    busy,
    input item_t   item,
    input logic    done,
    input result_t result
);

    // A full query holds the command channel off
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (item.command == CMD_QUERY) && item.dest_known) |=> busy)
        else $error("query accepted but busy not raised");

    // A table write answers in the next cycle
    a_write_ack: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (item.command == CMD_WRITE))
        |=> (done && (result.status == STAT_WRITTEN)))
        else $error("table write not acknowledged");

    // Release of busy comes with the query's answer
    a_busy_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result");

    // Statuses without a hop carry a zero address
    a_no_hop: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status == STAT_NONE || result.status == STAT_UNKNOWN
                  || result.status == STAT_WRITTEN)) |-> (result.next_hop == '0))
        else $error("nonzero next hop without a chosen neighbor");

endmodule

bind greedy_next_hop_select gnh_checker u_gnh_checker (.*);
